[hw/rtl/multi_channel_soft_timer_table_defines.svh]
// Assertion macros for the soft timer table.
// The assertions sample on clk and are held off while rst_n is low.
`ifndef MULTI_CHANNEL_SOFT_TIMER_TABLE_DEFINES_SVH
`define MULTI_CHANNEL_SOFT_TIMER_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define MCST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MCST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCST_ASSERT_IMP(label, ante, cons, msg)
`define MCST_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[hw/rtl/mcst_pkg.sv]
package mcst_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SCAN_W     = IDX_W + 1;

    localparam int ACT_W    = 3;
    localparam int TIME_W   = 32;
    localparam int ID_W     = 4;
    localparam int PMS_W    = 19;
    localparam int TPS_W    = 14;
    localparam int STATUS_W = 2;
    localparam int RID_W    = 3;

    localparam int PROD_W        = PMS_W + TPS_W;
    localparam int MS_PER_SECOND = 1000;

    // x / 1000 == (x >> 3) / 125; for a 30-bit value the divide by 125 is exact as
    // (x * ceil(2^37 / 125)) >> 37
    localparam int DIV_PRE_SHIFT = 3;
    localparam int QIN_W         = PROD_W - DIV_PRE_SHIFT;
    localparam int RECIP_W       = 31;
    localparam int RECIP_SHIFT   = 37;
    localparam int QPROD_W       = QIN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_125 = 31'd1099511628;

    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [TPS_W-1:0] TPS_RESET = 14'd15993;

    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MODIFY  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_KILL    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESTART = 3'd4;
    localparam logic [ACT_W-1:0] ACT_STOP    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ERR     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXPIRED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOEXP   = 2'd3;

    typedef enum logic [1:0] {
        SLOT_FREE,
        SLOT_RUN,
        SLOT_STOP
    } slot_state_t;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_SET,
        OP_MODIFY,
        OP_KILL,
        OP_RESTART,
        OP_STOP,
        OP_ERROR
    } op_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ONE,
        B_SET,
        B_TICK
    } back_state_t;

    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] now;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] per;
        logic              ss;
    } cmd_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [RID_W-1:0]    id;
        logic                last;
    } result_t;

    // slot index as reported: zero-extended or cut to the result id width
    function automatic logic [RID_W-1:0] report_id(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[RID_W-1:0];
    endfunction

endpackage

[hw/rtl/mcst_front.sv]
module mcst_front
    import mcst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ACT_W-1:0]  action,
    input  logic [TIME_W-1:0] now_time,
    input  logic [ID_W-1:0]   target_id,
    input  logic [PMS_W-1:0]  period_ms,
    input  logic              single_shot,
    input  logic [TPS_W-1:0]  tps,
    output logic              busy,
    output logic              push,
    output cmd_t              push_cmd,
    input  logic              full
);

    front_state_t          state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [PROD_W-1:0]     work_reg, work_next;

    logic [QPROD_W-1:0]    recip_prod;
    logic                  id_ok;

    // divide by 1000: drop 3 low bits, then reciprocal multiply for 125
    assign recip_prod = QPROD_W'(work_reg[PROD_W-1:DIV_PRE_SHIFT]) * QPROD_W'(RECIP_125);
    assign id_ok      = 32'(target_id) < NUM_TIMERS;

    assign busy     = state_reg != F_IDLE;
    assign push_cmd = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        work_reg <= work_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        work_next  = work_reg;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    cmd_next.now = now_time;
                    cmd_next.idx = IDX_W'(target_id);
                    cmd_next.per = '0;
                    cmd_next.ss  = single_shot;
                    case (action)
                        ACT_TICK:    cmd_next.op = OP_TICK;
                        ACT_SET:     cmd_next.op = (period_ms != '0) ? OP_SET : OP_ERROR;
                        ACT_MODIFY:  cmd_next.op = id_ok ? OP_MODIFY : OP_ERROR;
                        ACT_KILL:    cmd_next.op = id_ok ? OP_KILL : OP_ERROR;
                        ACT_RESTART: cmd_next.op = id_ok ? OP_RESTART : OP_ERROR;
                        ACT_STOP:    cmd_next.op = id_ok ? OP_STOP : OP_ERROR;
                        default:     cmd_next.op = OP_ERROR;
                    endcase
                    work_next = PROD_W'(period_ms) * PROD_W'(tps);
                    if (cmd_next.op == OP_SET || cmd_next.op == OP_MODIFY)
                    begin
                        state_next = F_DIV;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_DIV:
            begin
                cmd_next.per = TIME_W'(recip_prod[QPROD_W-1:RECIP_SHIFT]);
                state_next   = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/mcst_cmd_fifo.sv]
module mcst_cmd_fifo
    import mcst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head_cmd,
    output logic head_valid
);

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = count_reg == CMDQ_CNT_W'(CMDQ_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/mcst_back.sv]
module mcst_back
    import mcst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  cmd_t    head_cmd,
    output logic    pop,
    output result_t res
);

    slot_state_t        slot_st_reg  [NUM_TIMERS];
    logic               slot_ss_reg  [NUM_TIMERS];
    logic [TIME_W-1:0]  slot_per_reg [NUM_TIMERS];
    logic [TIME_W-1:0]  slot_exp_reg [NUM_TIMERS];

    back_state_t        bstate_reg, bstate_next;
    cmd_t               cur_reg, cur_next;
    logic [SCAN_W-1:0]  scan_reg, scan_next;
    result_t            res_reg, res_next;

    // tick pipeline: stage A reads one slot, stage B writes it back
    logic               a_valid_reg, a_valid_next;
    logic [IDX_W-1:0]   a_idx_reg, a_idx_next;
    logic               a_run_reg, a_run_next;
    logic               a_ss_reg, a_ss_next;
    logic               a_expired_reg, a_expired_next;
    logic [TIME_W-1:0]  a_per_reg, a_per_next;
    logic [TIME_W-1:0]  a_exp_reg, a_exp_next;
    logic [TIME_W-1:0]  a_diff_reg, a_diff_next;
    logic [TIME_W-1:0]  a_lim_reg, a_lim_next;
    logic [TIME_W-1:0]  a_sum_reg, a_sum_next;

    logic               pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;

    logic [IDX_W-1:0]   rd_idx;
    slot_state_t        rd_st;
    logic               rd_ss;
    logic [TIME_W-1:0]  rd_per;
    logic [TIME_W-1:0]  rd_exp;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    slot_state_t        wr_st;
    logic               wr_ss;
    logic [TIME_W-1:0]  wr_per;
    logic [TIME_W-1:0]  wr_exp;

    logic               issue;
    logic [TIME_W-1:0]  exp_adv;
    logic [TIME_W-1:0]  exp_fin;

    assign res    = res_reg;
    assign rd_idx = (bstate_reg == B_SET || bstate_reg == B_TICK) ? scan_reg[IDX_W-1:0]
                                                                  : cur_reg.idx;
    assign rd_st  = slot_st_reg[rd_idx];
    assign rd_ss  = slot_ss_reg[rd_idx];
    assign rd_per = slot_per_reg[rd_idx];
    assign rd_exp = slot_exp_reg[rd_idx];

    assign issue  = scan_reg < SCAN_W'(NUM_TIMERS);

    // when expired, advance by one period unless the slot fell behind, then clamp to now + period
    assign exp_adv = !a_expired_reg        ? a_exp_reg :
                     (a_per_reg > a_diff_reg) ? a_sum_reg : a_lim_reg;
    assign exp_fin = (a_lim_reg < exp_adv) ? a_lim_reg : exp_adv;

    always_comb
    begin
        bstate_next     = bstate_reg;
        cur_next        = cur_reg;
        scan_next       = scan_reg;
        res_next        = '0;
        pop             = 1'b0;
        a_valid_next    = 1'b0;
        a_idx_next      = a_idx_reg;
        a_run_next      = a_run_reg;
        a_ss_next       = a_ss_reg;
        a_expired_next  = a_expired_reg;
        a_per_next      = a_per_reg;
        a_exp_next      = a_exp_reg;
        a_diff_next     = a_diff_reg;
        a_lim_next      = a_lim_reg;
        a_sum_next      = a_sum_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        n_next          = n_reg;
        wr_en           = 1'b0;
        wr_idx          = cur_reg.idx;
        wr_st           = rd_st;
        wr_ss           = rd_ss;
        wr_per          = rd_per;
        wr_exp          = rd_exp;
        case (bstate_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    pop             = 1'b1;
                    cur_next        = head_cmd;
                    scan_next       = '0;
                    pend_valid_next = 1'b0;
                    n_next          = '0;
                    case (head_cmd.op)
                        OP_TICK: bstate_next = B_TICK;
                        OP_SET:  bstate_next = B_SET;
                        default: bstate_next = B_ONE;
                    endcase
                end
            end
            B_ONE:
            begin
                case (cur_reg.op)
                    OP_MODIFY:
                    begin
                        wr_en  = 1'b1;
                        wr_per = cur_reg.per;
                        wr_exp = cur_reg.now + cur_reg.per;
                    end
                    OP_KILL:
                    begin
                        wr_en = 1'b1;
                        wr_st = SLOT_FREE;
                    end
                    OP_RESTART:
                    begin
                        wr_en  = 1'b1;
                        wr_exp = cur_reg.now + rd_per;
                        wr_st  = SLOT_RUN;
                    end
                    OP_STOP:
                    begin
                        wr_en = 1'b1;
                        wr_st = SLOT_STOP;
                    end
                    default:
                    begin
                        wr_en = 1'b0;
                    end
                endcase
                res_next.valid  = 1'b1;
                res_next.status = (cur_reg.op == OP_ERROR) ? ST_ERR : ST_OK;
                res_next.last   = 1'b1;
                bstate_next     = B_IDLE;
            end
            B_SET:
            begin
                if (rd_st == SLOT_FREE)
                begin
                    wr_en           = 1'b1;
                    wr_idx          = rd_idx;
                    wr_st           = SLOT_RUN;
                    wr_ss           = cur_reg.ss;
                    wr_per          = cur_reg.per;
                    wr_exp          = cur_reg.now + cur_reg.per;
                    res_next.valid  = 1'b1;
                    res_next.status = ST_OK;
                    res_next.id     = report_id(rd_idx);
                    res_next.last   = 1'b1;
                    bstate_next     = B_IDLE;
                end
                else if (scan_reg == SCAN_W'(NUM_TIMERS - 1))
                begin
                    res_next.valid  = 1'b1;
                    res_next.status = ST_ERR;
                    res_next.last   = 1'b1;
                    bstate_next     = B_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            B_TICK:
            begin
                if (issue)
                begin
                    a_valid_next   = 1'b1;
                    a_idx_next     = rd_idx;
                    a_run_next     = rd_st == SLOT_RUN;
                    a_ss_next      = rd_ss;
                    a_per_next     = rd_per;
                    a_exp_next     = rd_exp;
                    a_expired_next = cur_reg.now >= rd_exp;
                    a_diff_next    = cur_reg.now - rd_exp;
                    a_lim_next     = cur_reg.now + rd_per;
                    a_sum_next     = rd_exp + rd_per;
                    scan_next      = scan_reg + 1'b1;
                end
                if (a_valid_reg && a_run_reg)
                begin
                    wr_en  = 1'b1;
                    wr_idx = a_idx_reg;
                    wr_st  = (a_expired_reg && a_ss_reg) ? SLOT_FREE : SLOT_RUN;
                    wr_ss  = a_ss_reg;
                    wr_per = a_per_reg;
                    wr_exp = exp_fin;
                    // hold each expiry back one report so the final one can carry last
                    if (a_expired_reg && n_reg < RES_CNT_W'(MAX_RESULTS))
                    begin
                        if (pend_valid_reg)
                        begin
                            res_next.valid  = 1'b1;
                            res_next.status = ST_EXPIRED;
                            res_next.id     = report_id(pend_idx_reg);
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = a_idx_reg;
                        n_next          = n_reg + 1'b1;
                    end
                end
                if (!issue && !a_valid_reg)
                begin
                    res_next.valid  = 1'b1;
                    res_next.status = pend_valid_reg ? ST_EXPIRED : ST_NOEXP;
                    res_next.id     = pend_valid_reg ? report_id(pend_idx_reg) : '0;
                    res_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    bstate_next     = B_IDLE;
                end
            end
            default:
            begin
                bstate_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg     <= B_IDLE;
            res_reg        <= '0;
            a_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                slot_st_reg[i]  <= SLOT_FREE;
                slot_ss_reg[i]  <= 1'b0;
                slot_per_reg[i] <= '0;
                slot_exp_reg[i] <= '0;
            end
        end
        else
        begin
            bstate_reg     <= bstate_next;
            res_reg        <= res_next;
            a_valid_reg    <= a_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (wr_en)
            begin
                slot_st_reg[wr_idx]  <= wr_st;
                slot_ss_reg[wr_idx]  <= wr_ss;
                slot_per_reg[wr_idx] <= wr_per;
                slot_exp_reg[wr_idx] <= wr_exp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        scan_reg      <= scan_next;
        a_idx_reg     <= a_idx_next;
        a_run_reg     <= a_run_next;
        a_ss_reg      <= a_ss_next;
        a_expired_reg <= a_expired_next;
        a_per_reg     <= a_per_next;
        a_exp_reg     <= a_exp_next;
        a_diff_reg    <= a_diff_next;
        a_lim_reg     <= a_lim_next;
        a_sum_reg     <= a_sum_next;
        pend_idx_reg  <= pend_idx_next;
        n_reg         <= n_next;
    end

endmodule

[hw/rtl/multi_channel_soft_timer_table.sv]
// channel   handshake                   payload
// ------    --------------------------  ----------------------------------------------
// command   start, busy (start & !busy) action, now_time, target_id, period_ms, single_shot
// result    result_valid (1-cycle)      status, result_id, last
// config    cfg_valid, cfg_ready        cfg_data (ticks_per_second)
//
// Front: busy is high until the taken command is pushed; set/modify first pass F_DIV (ms
// product registered on accept, then shift-by-3 and reciprocal multiply for 125).
// Back: tick reads one slot per cycle through a two-stage read/update pipeline; set scans
// up to NUM_TIMERS slots; other commands are handled in B_ONE.
// Reset clears all slots to free with zero period and expiry, tick rate to 15993.
// The result side cannot stall; a full 2-word queue holds off the front via busy.
`include "multi_channel_soft_timer_table_defines.svh"

module multi_channel_soft_timer_table
    import mcst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ACT_W-1:0]    action,
    input  logic [TIME_W-1:0]   now_time,
    input  logic [ID_W-1:0]     target_id,
    input  logic [PMS_W-1:0]    period_ms,
    input  logic                single_shot,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [TPS_W-1:0]    cfg_data,
    output logic                result_valid,
    output logic [STATUS_W-1:0] status,
    output logic [RID_W-1:0]    result_id,
    output logic                last
);

    logic [TPS_W-1:0] tps_reg;
    logic             push;
    cmd_t             push_cmd;
    logic             full;
    logic             pop;
    cmd_t             head_cmd;
    logic             head_valid;
    result_t          res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tps_reg <= cfg_data;
        end
    end

    mcst_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .now_time    (now_time),
        .target_id   (target_id),
        .period_ms   (period_ms),
        .single_shot (single_shot),
        .tps         (tps_reg),
        .busy        (busy),
        .push        (push),
        .push_cmd    (push_cmd),
        .full        (full)
    );

    mcst_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid)
    );

    mcst_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .res        (res)
    );

    assign result_valid = res.valid;
    assign status       = res.status;
    assign result_id    = res.id;
    assign last         = res.last;

    `MCST_ASSERT_NXT(a_accept_busy, start && !busy, busy, "front idle right after a command")
    `MCST_ASSERT_IMP(a_nonlast_expiry, result_valid && !last, status == ST_EXPIRED,
                     "only expiry words may be non-final")
    `MCST_ASSERT_NXT(a_gap_after_last, result_valid && last, !result_valid,
                     "result word right after a final word")

endmodule

[bench/multi_channel_soft_timer_table_checker.sv]
module multi_channel_soft_timer_table_checker
    import mcst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [ACT_W-1:0]    action,
    input  logic [TIME_W-1:0]   now_time,
    input  logic [ID_W-1:0]     target_id,
    input  logic [PMS_W-1:0]    period_ms,
    input  logic                single_shot,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [TPS_W-1:0]    cfg_data,
    input  logic                result_valid,
    input  logic [STATUS_W-1:0] status,
    input  logic [RID_W-1:0]    result_id,
    input  logic                last,
    output int                  n_fail,
    output int                  n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RID_W-1:0]    id;
        logic                last;
    } timer_word_t;

    slot_state_t       slot_st   [NUM_TIMERS];
    logic              one_shot  [NUM_TIMERS];
    logic [TIME_W-1:0] per_ticks [NUM_TIMERS];
    logic [TIME_W-1:0] due_at    [NUM_TIMERS];
    logic [TPS_W-1:0]  rate;
    timer_word_t       due_words [$];
    int                mism;

    function automatic logic [TIME_W-1:0] ms_to_ticks(input logic [PMS_W-1:0] ms);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(ms) * PROD_W'(rate);
        return TIME_W'(prod / PROD_W'(MS_PER_SECOND));
    endfunction

    function automatic timer_word_t word_of(input logic [STATUS_W-1:0] st,
                                            input logic [RID_W-1:0] id,
                                            input logic lst);
        timer_word_t w;
        w.status = st;
        w.id     = id;
        w.last   = lst;
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mism++;
    endtask

    task automatic predict_action(input logic [ACT_W-1:0]  act,
                                  input logic [TIME_W-1:0] t,
                                  input logic [ID_W-1:0]   id,
                                  input logic [PMS_W-1:0]  pms,
                                  input logic              ss);
        timer_word_t       hits [MAX_RESULTS];
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] lim;
        logic [IDX_W-1:0]  slot;
        int                n;
        bit                placed;
        n      = 0;
        placed = 1'b0;
        slot   = id[IDX_W-1:0];
        case (act)
            ACT_TICK: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (slot_st[i] == SLOT_RUN) begin
                        per = per_ticks[i];
                        if (t >= due_at[i]) begin
                            if (one_shot[i])
                                slot_st[i] = SLOT_FREE;
                            // fell behind by a full period or more: re-base on now
                            if (per > t - due_at[i])
                                due_at[i] = due_at[i] + per;
                            else
                                due_at[i] = t + per;
                            if (n < MAX_RESULTS) begin
                                hits[n] = word_of(ST_EXPIRED, RID_W'(i), 1'b0);
                                n++;
                            end
                        end
                        lim = t + per;
                        if (lim < due_at[i])
                            due_at[i] = lim;
                    end
                end
                if (n == 0)
                    due_words.push_back(word_of(ST_NOEXP, '0, 1'b1));
                else begin
                    hits[n-1].last = 1'b1;
                    for (int k = 0; k < n; k++)
                        due_words.push_back(hits[k]);
                end
            end
            ACT_SET: begin
                if (pms != '0) begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (!placed && slot_st[i] == SLOT_FREE) begin
                            per_ticks[i] = ms_to_ticks(pms);
                            due_at[i]    = t + per_ticks[i];
                            slot_st[i]   = SLOT_RUN;
                            one_shot[i]  = ss;
                            placed       = 1'b1;
                            due_words.push_back(word_of(ST_OK, RID_W'(i), 1'b1));
                        end
                    end
                end
                if (!placed)
                    due_words.push_back(word_of(ST_ERR, '0, 1'b1));
            end
            ACT_MODIFY, ACT_KILL, ACT_RESTART, ACT_STOP: begin
                if (id >= NUM_TIMERS)
                    due_words.push_back(word_of(ST_ERR, '0, 1'b1));
                else begin
                    case (act)
                        ACT_MODIFY: begin
                            per_ticks[slot] = ms_to_ticks(pms);
                            due_at[slot]    = t + per_ticks[slot];
                        end
                        ACT_KILL:    slot_st[slot] = SLOT_FREE;
                        ACT_RESTART: begin
                            due_at[slot]  = t + per_ticks[slot];
                            slot_st[slot] = SLOT_RUN;
                        end
                        default:     slot_st[slot] = SLOT_STOP;
                    endcase
                    due_words.push_back(word_of(ST_OK, '0, 1'b1));
                end
            end
            default: due_words.push_back(word_of(ST_ERR, '0, 1'b1));
        endcase
    endtask

    // results first, then config, then the new word: a result seen at this edge
    // always belongs to an earlier word
    always @(posedge clk or negedge rst_n) begin : watch
        timer_word_t want;
        if (!rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                slot_st[i]   = SLOT_FREE;
                one_shot[i]  = 1'b0;
                per_ticks[i] = '0;
                due_at[i]    = '0;
            end
            rate = TPS_RESET;
            due_words.delete();
            mism = 0;
            n_fail    <= 0;
            n_pending <= 0;
        end else begin
            if (result_valid) begin
                if (due_words.size() == 0)
                    report_mismatch($sformatf("result word with nothing expected, status %0d id %0d",
                                              status, result_id));
                else begin
                    want = due_words.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  status, want.status));
                    if (result_id !== want.id)
                        report_mismatch($sformatf("result_id got %0d expected %0d",
                                                  result_id, want.id));
                    if (last !== want.last)
                        report_mismatch($sformatf("last got %0d expected %0d",
                                                  last, want.last));
                end
            end
            if (cfg_valid && cfg_ready)
                rate = cfg_data;
            if (start && !busy)
                predict_action(action, now_time, target_id, period_ms, single_shot);
            n_pending <= due_words.size();
            n_fail    <= mism;
        end
    end

endmodule

[bench/multi_channel_soft_timer_table_tb.sv]
module multi_channel_soft_timer_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mcst_pkg::*;

    // actions 6 and 7 have no meaning and must be rejected
    localparam logic [ACT_W-1:0] ACT_BAD_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_BAD_HI = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [ACT_W-1:0]    action;
    logic [TIME_W-1:0]   now_time;
    logic [ID_W-1:0]     target_id;
    logic [PMS_W-1:0]    period_ms;
    logic                single_shot;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [TPS_W-1:0]    cfg_data;
    logic                result_valid;
    logic [STATUS_W-1:0] status;
    logic [RID_W-1:0]    result_id;
    logic                last;
    int                  n_fail;
    int                  n_pending;

    logic [TIME_W-1:0]   sim_now;
    logic [TPS_W-1:0]    cur_tps;

    multi_channel_soft_timer_table u_dut (.*);

    multi_channel_soft_timer_table_checker u_check (.*);

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_word(input logic [ACT_W-1:0]  act,
                             input logic [TIME_W-1:0] t,
                             input logic [ID_W-1:0]   id,
                             input logic [PMS_W-1:0]  pms,
                             input logic              ss);
        start       <= 1'b1;
        action      <= act;
        now_time    <= t;
        target_id   <= id;
        period_ms   <= pms;
        single_shot <= ss;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // n must be at least 1 so start is never dropped and raised in one step
    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    initial begin
        int                sent;
        int                burst;
        int                pick;
        int                t;
        logic [ACT_W-1:0]  act;
        logic [31:0]       pms;
        logic [31:0]       tgt;
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = '0;
        now_time    = '0;
        target_id   = '0;
        period_ms   = '0;
        single_shot = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, default tick rate
        send_word(ACT_TICK, 32'd100, 4'd0, 19'd0, 1'b0);
        send_word(ACT_SET, 32'd100, 4'd0, 19'd0, 1'b1);
        send_word(ACT_SET, 32'd100, 4'd0, 19'd1, 1'b1);
        send_word(ACT_SET, 32'd100, 4'd15, 19'h7FFFF, 1'b0);
        send_word(ACT_SET, 32'd100, 4'd0, 19'd268435, 1'b1);
        for (int k = 0; k < 5; k++)
            send_word(ACT_SET, 32'd101, 4'(k), 19'(2 * k + 2), 1'(k));
        send_word(ACT_SET, 32'd102, 4'd0, 19'd4, 1'b0);
        send_word(ACT_TICK, 32'd120, 4'd0, 19'd0, 1'b0);
        send_word(ACT_TICK, 32'h8000_0000, 4'd0, 19'd0, 1'b0);
        send_word(ACT_SET, 32'h8000_0000, 4'd0, 19'd1, 1'b0);
        // every running slot is due: an expiry word for each
        send_word(ACT_TICK, 32'hFFFF_FFFF, 4'd0, 19'd0, 1'b0);
        send_word(ACT_MODIFY, 32'd0, 4'd3, 19'd0, 1'b0);
        send_word(ACT_MODIFY, 32'd0, 4'd15, 19'd5, 1'b0);
        send_word(ACT_KILL, 32'd0, 4'd2, 19'd0, 1'b0);
        send_word(ACT_STOP, 32'd0, 4'd4, 19'd0, 1'b0);
        send_word(ACT_MODIFY, 32'd0, 4'd2, 19'd9, 1'b0);
        send_word(ACT_RESTART, 32'd0, 4'd2, 19'd0, 1'b0);
        send_word(ACT_RESTART, 32'd0, 4'd4, 19'd0, 1'b0);
        send_word(ACT_KILL, 32'd0, 4'd9, 19'd0, 1'b0);
        send_word(ACT_STOP, 32'd0, 4'd8, 19'd0, 1'b0);
        send_word(ACT_RESTART, 32'd0, 4'd12, 19'd0, 1'b0);
        send_word(ACT_BAD_LO, 32'd0, 4'd1, 19'd3, 1'b1);
        send_word(ACT_BAD_HI, 32'd0, 4'd1, 19'd3, 1'b1);
        send_word(ACT_TICK, 32'd0, 4'd0, 19'd0, 1'b0);

        for (int ph = 0; ph < 5; ph++) begin
            drain_results();
            case (ph)
                0:       cur_tps = 14'd1;
                1:       cur_tps = 14'd16383;
                2:       cur_tps = 14'd16000;
                3:       cur_tps = 14'($urandom_range(15999, 2));
                default: cur_tps = TPS_RESET;
            endcase
            cfg_valid <= 1'b1;
            cfg_data  <= cur_tps;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            // one phase starts just below the wrap of the time counter
            sim_now = (ph == 2) ? 32'hFFFF_F000 : $urandom();
            sent = 0;
            while (sent < 63) begin
                burst = $urandom_range(16, 1);
                for (int b = 0; b < burst; b++) begin
                    pick = $urandom_range(99);
                    if (pick < 40)
                        act = ACT_TICK;
                    else if (pick < 60)
                        act = ACT_SET;
                    else if (pick < 70)
                        act = ACT_MODIFY;
                    else if (pick < 80)
                        act = ACT_KILL;
                    else if (pick < 88)
                        act = ACT_RESTART;
                    else if (pick < 95)
                        act = ACT_STOP;
                    else
                        act = pick[0] ? ACT_BAD_HI : ACT_BAD_LO;
                    if (act == ACT_TICK)
                        sim_now = sim_now + (($urandom_range(49) == 0) ? $urandom()
                                                                       : $urandom_range(400));
                    else
                        sim_now = sim_now + $urandom_range(20);
                    tgt = ($urandom_range(9) == 0) ? $urandom_range(15, 8) : $urandom_range(7);
                    // period sized so expiries come within a few hundred counts
                    t   = $urandom_range(600, 1);
                    pms = 32'(t * 1000 / int'(cur_tps)) + 32'd1;
                    if (pms > 32'h7FFFF)
                        pms = 32'h7FFFF;
                    if ($urandom_range(19) == 0)
                        pms = $urandom_range(32'h7FFFF);
                    if ($urandom_range(29) == 0)
                        pms = '0;
                    send_word(act, sim_now, tgt[ID_W-1:0], pms[PMS_W-1:0],
                              1'($urandom_range(1)));
                    sent++;
                end
                if ($urandom_range(19) == 0)
                    drain_results();
                else if ($urandom_range(3) != 0)
                    hold_off($urandom_range(8, 1));
            end
        end

        drain_results();
        if (n_fail == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
